// ----- rtl/asmb_pkg.sv -----
// Shared types, constants and tables for the affine SRT matrix builder.
package asmb_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int FRAC_BITS    = 16;
	localparam int CW           = 34;   // Q30 working width
	localparam int DW           = 32;   // entry width
	localparam int STEP_W       = 5;

	typedef logic signed [CW-1:0] cw_t;

	localparam cw_t Q30_HALF_PI = 34'sd1686629713;
	localparam cw_t Q30_PI      = 34'sd3373259426;
	localparam cw_t CORDIC_GAIN = 34'sd652032874;

	localparam logic [1:0]    ROW_LAST  = 2'd3;
	localparam logic [DW-1:0] ONE_ENTRY = DW'(1) << FRAC_BITS;

	typedef struct packed {
		cw_t  x;
		cw_t  y;
		cw_t  z;
		logic neg;
	} lane_t;

	typedef struct packed {
		lane_t [2:0]          lane;
		logic  [2:0][DW-1:0]  scl;
		logic  [2:0][DW-1:0]  shf;
	} cstage_t;

	typedef struct packed {
		logic [2:0][2:0][DW-1:0] ent;
		logic [2:0]              ovf;
		logic [2:0][DW-1:0]      shf;
	} matrix_t;

	function automatic cw_t atan_q30(input logic [STEP_W-1:0] i);
		cw_t r;
		case (i)
			5'd0:    r = 34'sd843314857;
			5'd1:    r = 34'sd497837829;
			5'd2:    r = 34'sd263043837;
			5'd3:    r = 34'sd133525159;
			5'd4:    r = 34'sd67021687;
			5'd5:    r = 34'sd33543516;
			5'd6:    r = 34'sd16775851;
			5'd7:    r = 34'sd8388437;
			5'd8:    r = 34'sd4194283;
			5'd9:    r = 34'sd2097149;
			5'd10:   r = 34'sd1048576;
			5'd11:   r = 34'sd524288;
			5'd12:   r = 34'sd262144;
			5'd13:   r = 34'sd131072;
			5'd14:   r = 34'sd65536;
			5'd15:   r = 34'sd32768;
			5'd16:   r = 34'sd16384;
			5'd17:   r = 34'sd8192;
			5'd18:   r = 34'sd4096;
			5'd19:   r = 34'sd2048;
			5'd20:   r = 34'sd1024;
			5'd21:   r = 34'sd512;
			5'd22:   r = 34'sd256;
			5'd23:   r = 34'sd128;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/asmb_cordic_cell.sv -----
// One CORDIC rotation step for the three angle lanes, registered.
module asmb_cordic_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [asmb_pkg::STEP_W-1:0] step,
	input  logic                      in_valid,
	input  asmb_pkg::cstage_t         in_data,
	output logic                      out_valid,
	output asmb_pkg::cstage_t         out_data
);
	import asmb_pkg::*;

	cstage_t nxt;
	cw_t     at;
	logic    vld_q;
	cstage_t dat_q;

	always_comb begin
		cw_t xs, ys;
		logic pos;
		nxt = in_data;
		at  = atan_q30(step);
		for (int k = 0; k < 3; k++) begin
			xs  = $signed(in_data.lane[k].x) >>> step;
			ys  = $signed(in_data.lane[k].y) >>> step;
			pos = !in_data.lane[k].z[CW-1];
			if (pos) begin
				nxt.lane[k].x = in_data.lane[k].x - ys;
				nxt.lane[k].y = in_data.lane[k].y + xs;
				nxt.lane[k].z = in_data.lane[k].z - at;
			end else begin
				nxt.lane[k].x = in_data.lane[k].x + ys;
				nxt.lane[k].y = in_data.lane[k].y - xs;
				nxt.lane[k].z = in_data.lane[k].z + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) dat_q <= nxt;
	end

	assign out_valid = vld_q;
	assign out_data  = dat_q;
endmodule

// ----- rtl/asmb_rot_combine.sv -----
// Rotation product Rx*Ry*Rz, row scaling and saturation, four stages.
module asmb_rot_combine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  asmb_pkg::cstage_t in_data,
	output logic              out_valid,
	output asmb_pkg::matrix_t out_data
);
	import asmb_pkg::*;

	function automatic cw_t mul30(input cw_t a, input cw_t b);
		logic signed [2*CW-1:0] p;
		p = a * b + ((2*CW)'(1) <<< 29);
		return p[CW+29:30];
	endfunction

	function automatic logic signed [35:0] smul(input logic signed [DW-1:0] s, input cw_t r);
		logic signed [DW+CW-1:0] p;
		p = s * r + ((DW+CW)'(1) <<< 29);
		return p[DW+CW-1:30];
	endfunction

	cw_t sn [3];
	cw_t cs [3];

	// stage 1: products of sines and cosines
	logic v_s1;
	cw_t  cycz_s1, cysz_s1, sycz_s1, sysz_s1, cxnsz_s1, cxcz_s1, sxcy_s1;
	cw_t  nsxnsz_s1, nsxcz_s1, cxcy_s1, sx_s1, cx_s1, sy_s1;
	logic [2:0][DW-1:0] scl_s1, shf_s1, scl_s2, shf_s2, shf_s3;

	// stage 2: rotation entries
	logic v_s2;
	cw_t  r_s2 [3][3];

	// stage 3: scaled, rounded entries
	logic v_s3;
	logic signed [35:0] t_s3 [3][3];

	// stage 4: saturated result
	logic    v_s4;
	matrix_t sat_c;
	matrix_t mat_s4;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sn[k] = in_data.lane[k].neg ? -in_data.lane[k].y : in_data.lane[k].y;
			cs[k] = in_data.lane[k].neg ? -in_data.lane[k].x : in_data.lane[k].x;
		end
	end

	always_comb begin
		sat_c = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (t_s3[i][j] > 36'sd2147483647) begin
					sat_c.ent[i][j] = 32'h7fff_ffff;
					sat_c.ovf[i]    = 1'b1;
				end else if (t_s3[i][j] < -36'sd2147483648) begin
					sat_c.ent[i][j] = 32'h8000_0000;
					sat_c.ovf[i]    = 1'b1;
				end else begin
					sat_c.ent[i][j] = t_s3[i][j][DW-1:0];
				end
			end
		end
		sat_c.shf = shf_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cycz_s1   <= mul30(cs[1], cs[2]);
			cysz_s1   <= mul30(cs[1], sn[2]);
			sycz_s1   <= mul30(sn[1], cs[2]);
			sysz_s1   <= mul30(sn[1], sn[2]);
			cxnsz_s1  <= mul30(cs[0], -sn[2]);
			cxcz_s1   <= mul30(cs[0], cs[2]);
			sxcy_s1   <= mul30(sn[0], cs[1]);
			nsxnsz_s1 <= mul30(-sn[0], -sn[2]);
			nsxcz_s1  <= mul30(-sn[0], cs[2]);
			cxcy_s1   <= mul30(cs[0], cs[1]);
			sx_s1     <= sn[0];
			cx_s1     <= cs[0];
			sy_s1     <= sn[1];
			scl_s1    <= in_data.scl;
			shf_s1    <= in_data.shf;

			r_s2[0][0] <= cycz_s1;
			r_s2[0][1] <= cysz_s1;
			r_s2[0][2] <= -sy_s1;
			r_s2[1][0] <= cxnsz_s1 + mul30(sx_s1, sycz_s1);
			r_s2[1][1] <= cxcz_s1 + mul30(sx_s1, sysz_s1);
			r_s2[1][2] <= sxcy_s1;
			r_s2[2][0] <= nsxnsz_s1 + mul30(cx_s1, sycz_s1);
			r_s2[2][1] <= nsxcz_s1 + mul30(cx_s1, sysz_s1);
			r_s2[2][2] <= cxcy_s1;
			scl_s2     <= scl_s1;
			shf_s2     <= shf_s1;

			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					t_s3[i][j] <= smul($signed(scl_s2[i]), r_s2[i][j]);
			shf_s3 <= shf_s2;

			mat_s4 <= sat_c;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = mat_s4;
endmodule

// ----- rtl/asmb_row_out.sv -----
// Holds one finished matrix and sends it as four row transfers.
module asmb_row_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  asmb_pkg::matrix_t in_data,
	output logic              take,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [135:0]      m_tdata,   // row_index[1:0], col0..col3 (32 each), zero pad
	output logic              m_tlast,
	output logic              m_tuser    // overflow
);
	import asmb_pkg::*;

	logic       busy_q;
	logic [1:0] row_q;
	matrix_t    mat_q;
	logic       fire, load;
	logic [DW-1:0] c0, c1, c2, c3;
	logic       ovf;

	assign fire = busy_q && m_tready;
	assign take = !busy_q || (fire && row_q == ROW_LAST);
	assign load = take && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			row_q  <= '0;
		end else if (fire) begin
			if (row_q == ROW_LAST) busy_q <= 1'b0;
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) mat_q <= in_data;
	end

	always_comb begin
		if (row_q == ROW_LAST) begin
			c0  = mat_q.shf[0];
			c1  = mat_q.shf[1];
			c2  = mat_q.shf[2];
			c3  = ONE_ENTRY;
			ovf = 1'b0;
		end else begin
			c0  = mat_q.ent[row_q][0];
			c1  = mat_q.ent[row_q][1];
			c2  = mat_q.ent[row_q][2];
			c3  = '0;
			ovf = mat_q.ovf[row_q];
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = {6'd0, c3, c2, c1, c0, row_q};
	assign m_tlast  = (row_q == ROW_LAST);
	assign m_tuser  = ovf;

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && row_q == ROW_LAST && !in_valid) |=> !busy_q)
		else $error("row sender stayed busy after final row");
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && row_q != ROW_LAST) |=> (busy_q && row_q == $past(row_q) + 2'd1))
		else $error("row index did not advance");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !m_tready) |=> $stable(row_q))
		else $error("row index moved during stall");
endmodule

// ----- rtl/affine_srt_matrix_builder_top.sv -----
// An input passes the fold register, the CORDIC cells and the combine stages before its first row transfer.
// The row sender takes a new matrix only with the last of the four row transfers of the one it holds;
// the CORDIC cell chain and combine pipeline take a new item every cycle when not stalled.
// Reset clears all valid flags and the row sender; data registers are not reset.
// Top level of the scale-rotate-translate matrix builder.
module affine_srt_matrix_builder_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [239:0] s_tdata,  // scale_x,y,z (32 each), angle_x,y,z (16 each), shift_x,y,z (32 each)
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,  // row_index[1:0], col0..col3 (32 each), zero pad
	output logic         m_tlast,
	output logic         m_tuser   // overflow
);
	import asmb_pkg::*;

	logic    en, take, cmb_valid;
	matrix_t cmb_data;
	logic    vl [CORDIC_STEPS+1];
	cstage_t st [CORDIC_STEPS+1];
	logic    v_s0;
	cstage_t d_s0;
	cstage_t fold;

	assign en       = !cmb_valid || take;
	assign s_tready = en;

	// angle to Q30 and fold into the CORDIC range
	always_comb begin
		cw_t z;
		fold = '0;
		for (int k = 0; k < 3; k++) begin
			z = {s_tdata[96+16*k+15], s_tdata[96+16*k +: 16], 17'd0};
			fold.lane[k].neg = 1'b0;
			if (z > Q30_HALF_PI) begin
				z = z - Q30_PI;
				fold.lane[k].neg = 1'b1;
			end else if (z < -Q30_HALF_PI) begin
				z = z + Q30_PI;
				fold.lane[k].neg = 1'b1;
			end
			fold.lane[k].x = CORDIC_GAIN;
			fold.lane[k].y = '0;
			fold.lane[k].z = z;
			fold.scl[k]    = s_tdata[32*k +: 32];
			fold.shf[k]    = s_tdata[144+32*k +: 32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s0 <= 1'b0;
		else if (en) v_s0 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) d_s0 <= fold;
	end

	assign vl[0] = v_s0;
	assign st[0] = d_s0;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		asmb_cordic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.step     (STEP_W'(g)),
			.in_valid (vl[g]),
			.in_data  (st[g]),
			.out_valid(vl[g+1]),
			.out_data (st[g+1])
		);
	end

	asmb_rot_combine u_cmb (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vl[CORDIC_STEPS]),
		.in_data  (st[CORDIC_STEPS]),
		.out_valid(cmb_valid),
		.out_data (cmb_data)
	);

	asmb_row_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(cmb_valid),
		.in_data (cmb_data),
		.take    (take),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);
endmodule
